[hdl/bct_pkg.sv]
// bct_pkg: shared types and constants for the block chain table engine
// payload structs, command and status codes, link encodings; no dependencies
`timescale 1ns / 1ps

package bct_pkg;

  localparam int BCT_NUM_BLOCKS = 1024;
  localparam int BCT_MAX_BLOCKS = 1024;
  localparam int BLK_W          = 10;
  localparam int LINK_W         = 16;

  localparam logic [LINK_W-1:0] END_MARK  = 16'hFFFF;
  localparam logic [LINK_W-1:0] FREE_MARK = 16'h0000;

  typedef enum logic [1:0] {
    CMD_ALLOC  = 2'd0,
    CMD_FOLLOW = 2'd1,
    CMD_EXTEND = 2'd2,
    CMD_FREE   = 2'd3
  } bct_cmd_t;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_END  = 2'd1,
    STAT_FULL = 2'd2,
    STAT_FREE = 2'd3
  } bct_status_t;

  typedef struct packed {
    bct_cmd_t         cmd;
    logic [BLK_W-1:0] block_index;
  } bct_in_t;

  typedef struct packed {
    logic [BLK_W-1:0] result_block;
    bct_status_t      status;
  } bct_out_t;

endpackage

[hdl/block_chain_table_engine_core.sv]
// block_chain_table_engine_core: sequencer around the link table memory
// allocate scans one entry a cycle, free walks one link a cycle; one beat at a time
// allocate: scan to the first free entry or the table end; follow: read one link
// extend: follow, or at an end mark scan and write the new link; free: walk the chain
// throughput: one beat in flight, ready again once the result is registered
// reset: synchronous, then a clearing pass over min(NUM_BLOCKS,1024) entries, not ready
`timescale 1ns / 1ps

module block_chain_table_engine_core
  import bct_pkg::*;
#(
  parameter int NUM_BLOCKS = BCT_NUM_BLOCKS
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  bct_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output bct_out_t out_data
);

  localparam int ADDR_LIMIT = (NUM_BLOCKS < BCT_MAX_BLOCKS) ? NUM_BLOCKS : BCT_MAX_BLOCKS;
  localparam int AW         = $clog2(ADDR_LIMIT);
  localparam int CW         = AW + 1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_FCHK,
    S_WCHK,
    S_LINK,
    S_DONE
  } state_t;

  state_t           state_r;
  logic [CW-1:0]    cnt_r;
  logic             chk_vld_r;
  logic [AW-1:0]    chk_idx_r;
  logic [AW-1:0]    cur_r;
  logic [AW-1:0]    found_r;
  bct_cmd_t         cmd_r;
  logic [BLK_W-1:0] res_r;
  bct_status_t      stat_r;
  logic             out_valid_r;
  bct_out_t         out_data_r;

  logic              we;
  logic [AW-1:0]     waddr;
  logic [LINK_W-1:0] wdata;
  logic [AW-1:0]     raddr;
  logic [LINK_W-1:0] rdata;

  logic found;
  logic issuing;
  logic link_ok;
  logic idx_in_range;

  assign found        = chk_vld_r && (rdata == FREE_MARK);
  assign issuing      = (cnt_r < CW'(ADDR_LIMIT));
  assign link_ok      = (rdata != FREE_MARK) && (rdata != END_MARK) &&
                        (rdata < LINK_W'(ADDR_LIMIT));
  assign idx_in_range = ({1'b0, in_data.block_index} < (BLK_W+1)'(ADDR_LIMIT));

  // write port and read address selection
  always_comb begin
    we    = 1'b0;
    waddr = cur_r;
    wdata = FREE_MARK;
    raddr = cur_r;
    unique case (state_r)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = cnt_r[AW-1:0];
        wdata = (cnt_r < CW'(2)) ? END_MARK : FREE_MARK;
      end
      S_IDLE: begin
        raddr = in_data.block_index[AW-1:0];
      end
      S_SCAN: begin
        we    = found;
        waddr = chk_idx_r;
        wdata = END_MARK;
        raddr = cnt_r[AW-1:0];
      end
      S_LINK: begin
        we    = 1'b1;
        waddr = cur_r;
        wdata = LINK_W'(found_r);
      end
      S_WCHK: begin
        we    = 1'b1;
        waddr = cur_r;
        wdata = FREE_MARK;
        raddr = rdata[AW-1:0];
      end
      S_FCHK, S_DONE: begin
        raddr = cur_r;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  bct_link_ram #(
    .DEPTH (ADDR_LIMIT),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cnt_r       <= '0;
      chk_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          cnt_r <= cnt_r + CW'(1);
          if (cnt_r[AW-1:0] == AW'(ADDR_LIMIT - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            cmd_r     <= in_data.cmd;
            cur_r     <= in_data.block_index[AW-1:0];
            cnt_r     <= '0;
            chk_vld_r <= 1'b0;
            res_r     <= '0;
            if (in_data.cmd == CMD_ALLOC) begin
              state_r <= S_SCAN;
            end else if (!idx_in_range) begin
              stat_r  <= STAT_FREE;
              state_r <= S_DONE;
            end else if (in_data.cmd == CMD_FREE) begin
              state_r <= S_WCHK;
            end else begin
              state_r <= S_FCHK;
            end
          end
        end
        S_SCAN: begin
          if (issuing) begin
            cnt_r <= cnt_r + CW'(1);
          end
          chk_vld_r <= issuing && !found;
          chk_idx_r <= cnt_r[AW-1:0];
          if (found) begin
            found_r <= chk_idx_r;
            if (cmd_r == CMD_EXTEND) begin
              state_r <= S_LINK;
            end else begin
              res_r   <= BLK_W'(chk_idx_r);
              stat_r  <= STAT_OK;
              state_r <= S_DONE;
            end
          end else if (!chk_vld_r && !issuing) begin
            res_r   <= '0;
            stat_r  <= STAT_FULL;
            state_r <= S_DONE;
          end
        end
        S_FCHK: begin
          if (rdata == END_MARK) begin
            if (cmd_r == CMD_EXTEND) begin
              state_r <= S_SCAN;
            end else begin
              stat_r  <= STAT_END;
              state_r <= S_DONE;
            end
          end else if (link_ok) begin
            res_r   <= rdata[BLK_W-1:0];
            stat_r  <= STAT_OK;
            state_r <= S_DONE;
          end else begin
            stat_r  <= STAT_FREE;
            state_r <= S_DONE;
          end
        end
        S_LINK: begin
          res_r   <= BLK_W'(found_r);
          stat_r  <= STAT_OK;
          state_r <= S_DONE;
        end
        S_WCHK: begin
          if (rdata == END_MARK) begin
            stat_r  <= STAT_OK;
            state_r <= S_DONE;
          end else if (link_ok && (rdata != LINK_W'(cur_r))) begin
            cur_r <= rdata[AW-1:0];
          end else begin
            // self link reads as free once this entry is cleared
            stat_r  <= STAT_FREE;
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r             <= 1'b1;
            out_data_r.result_block <= res_r;
            out_data_r.status       <= stat_r;
            state_r                 <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[hdl/bct_link_ram.sv]
// bct_link_ram: link table storage, one write port and one registered read port
// depends on bct_pkg for the link width
`timescale 1ns / 1ps

module bct_link_ram
  import bct_pkg::*;
#(
  parameter int DEPTH = BCT_MAX_BLOCKS,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [LINK_W-1:0] wdata,
  input  logic [AW-1:0]     raddr,
  output logic [LINK_W-1:0] rdata
);

  logic [LINK_W-1:0] mem [DEPTH];
  logic [LINK_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[hdl/bct_checker.sv]
// bct_checker: port-level assertions for block_chain_table_engine_core
// depends on bct_pkg; bound to block_chain_table_engine_core at the end of this file
`timescale 1ns / 1ps

module bct_checker
  import bct_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_ready,
  input bct_in_t  in_data,
  input logic     out_valid,
  input logic     out_ready,
  input bct_out_t out_data
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // only a successful beat carries a block index
  a_res_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != STAT_OK) |-> (out_data.result_block == '0))
    else $error("non-zero block on a failing status");

  // one beat at a time
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready straight after an accepted beat");

  // clearing pass follows reset
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !in_ready && !out_valid)
    else $error("ready or valid right after reset");

endmodule

bind block_chain_table_engine_core bct_checker u_bct_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

[verif/block_chain_table_engine_core_tb.sv]
// block_chain_table_engine_core_tb: self-checking bench for the block chain link table engine
// keeps a shadow link table to predict each result beat; needs bct_pkg and the core only
`timescale 1ns / 1ps

module block_chain_table_engine_core_tb;
  import bct_pkg::*;

  localparam int TABLE_DEPTH = (BCT_NUM_BLOCKS < 1024) ? BCT_NUM_BLOCKS : 1024;
  localparam int STALL_LIMIT = 20000;
  localparam int LONG_HOLD   = 300;
  localparam int MAX_SHOWN   = 10;
  localparam int PICK_ANY    = 0;
  localparam int PICK_USED   = 1;
  localparam int PICK_TAIL   = 2;

  class chain_table_scoreboard;
    logic [LINK_W-1:0] link_shadow [BCT_MAX_BLOCKS];
    bct_out_t          awaited_results[$];
    int                mismatch_count;

    function new();
      mismatch_count = 0;
      foreach (link_shadow[i]) link_shadow[i] = FREE_MARK;
      link_shadow[0] = END_MARK;
      link_shadow[1] = END_MARK;
    endfunction

    function logic [LINK_W-1:0] read_link(logic [BLK_W-1:0] idx);
      if (idx >= TABLE_DEPTH) return FREE_MARK;
      return link_shadow[idx];
    endfunction

    function bit is_next_link(logic [LINK_W-1:0] v);
      return v != FREE_MARK && v != END_MARK && v < TABLE_DEPTH;
    endfunction

    function bit claim_lowest(output logic [BLK_W-1:0] where);
      where = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        if (link_shadow[i] == FREE_MARK) begin
          link_shadow[i] = END_MARK;
          where = BLK_W'(i);
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    function void note_command(bct_in_t beat);
      bct_out_t          r;
      logic [LINK_W-1:0] v;
      logic [BLK_W-1:0]  idx;
      logic [BLK_W-1:0]  nb;
      r.result_block = '0;
      r.status = STAT_OK;
      idx = beat.block_index;
      case (beat.cmd)
        CMD_ALLOC: begin
          if (claim_lowest(nb)) r.result_block = nb;
          else r.status = STAT_FULL;
        end
        CMD_FOLLOW, CMD_EXTEND: begin
          v = read_link(idx);
          if (v == END_MARK) begin
            if (beat.cmd == CMD_EXTEND) begin
              if (claim_lowest(nb)) begin
                link_shadow[idx] = LINK_W'(nb);
                r.result_block = nb;
              end else begin
                r.status = STAT_FULL;
              end
            end else begin
              r.status = STAT_END;
            end
          end else if (is_next_link(v)) begin
            r.result_block = v[BLK_W-1:0];
          end else begin
            r.status = STAT_FREE;
          end
        end
        default: begin
          // walk and clear, stopping at the end mark or at an entry that is not a valid link
          r.status = STAT_FREE;
          for (int steps = 0; steps <= TABLE_DEPTH; steps++) begin
            v = read_link(idx);
            if (idx < TABLE_DEPTH) link_shadow[idx] = FREE_MARK;
            if (v == END_MARK) begin
              r.status = STAT_OK;
              break;
            end
            if (!is_next_link(v)) break;
            idx = v[BLK_W-1:0];
          end
        end
      endcase
      awaited_results.push_back(r);
    endfunction

    function void check_result(bct_out_t got);
      bct_out_t want;
      if (awaited_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_SHOWN)
          $display("unexpected result beat: block %0d status %0d", got.result_block, got.status);
        return;
      end
      want = awaited_results.pop_front();
      if (got.result_block !== want.result_block || got.status !== want.status) begin
        mismatch_count++;
        if (mismatch_count <= MAX_SHOWN)
          $display("mismatch at %0t: expected block %0d status %s, got block %0d status %0d",
                   $realtime, want.result_block, want.status.name(), got.result_block,
                   got.status);
      end
    endfunction

    function bit failed();
      return mismatch_count != 0 || awaited_results.size() != 0;
    endfunction
  endclass

  logic     clk;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  bct_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  bct_out_t out_data;

  chain_table_scoreboard sb = new();

  int tx_idle_pct    = 0;
  int rx_idle_pct    = 0;
  int hold_left      = 0;
  bit long_hold_req  = 1'b0;
  bit long_hold_done = 1'b0;
  int stall_cycles   = 0;

  block_chain_table_engine_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // result side: random stalls plus one long hold-off
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready = 1'b0;
      hold_left--;
    end else if (long_hold_req && !long_hold_done) begin
      long_hold_done = 1'b1;
      hold_left = LONG_HOLD;
      out_ready = 1'b0;
    end else begin
      out_ready = ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // beat monitor and watchdog
  always @(posedge clk) begin
    if (out_valid && out_ready) sb.check_result(out_data);
    if (in_valid && in_ready) sb.note_command(in_data);
    if ((out_valid && out_ready) || (in_valid && in_ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  task automatic send_cmd(bct_cmd_t c, logic [BLK_W-1:0] idx);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_data = '{cmd: c, block_index: idx};
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  function automatic logic [BLK_W-1:0] pick_block(int kind);
    int               start;
    int               j;
    logic [LINK_W-1:0] v;
    start = $urandom_range(0, 2 ** BLK_W - 1);
    if (kind != PICK_ANY) begin
      for (int k = 0; k < TABLE_DEPTH; k++) begin
        j = (start + k) % TABLE_DEPTH;
        v = sb.link_shadow[j];
        if ((kind == PICK_USED && v != FREE_MARK) || (kind == PICK_TAIL && v == END_MARK))
          return BLK_W'(j);
      end
    end
    return BLK_W'(start);
  endfunction

  task automatic run_random(int count, int free_weight);
    int       w;
    int       p;
    int       rest;
    bct_cmd_t c;
    rest = 100 - free_weight;
    repeat (count) begin
      w = $urandom_range(0, 99);
      if (w < free_weight) c = CMD_FREE;
      else if (w < free_weight + rest / 4) c = CMD_ALLOC;
      else if (w < free_weight + rest / 2) c = CMD_FOLLOW;
      else c = CMD_EXTEND;
      p = $urandom_range(0, 99);
      send_cmd(c, pick_block(p < 60 ? PICK_USED : (p < 85 ? PICK_TAIL : PICK_ANY)));
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    tx_idle_pct = 28;
    rx_idle_pct = 79;
    // directed: chain build, walk, partial free, broken chain, index extremes
    send_cmd(CMD_ALLOC, 10'd1023);
    send_cmd(CMD_FOLLOW, 10'd0);
    send_cmd(CMD_FOLLOW, 10'd1023);
    send_cmd(CMD_EXTEND, 10'd2);
    send_cmd(CMD_FOLLOW, 10'd2);
    send_cmd(CMD_EXTEND, 10'd2);
    send_cmd(CMD_EXTEND, 10'd3);
    send_cmd(CMD_FOLLOW, 10'd3);
    send_cmd(CMD_FOLLOW, 10'd4);
    send_cmd(CMD_EXTEND, 10'd1023);
    send_cmd(CMD_FREE, 10'd4);
    send_cmd(CMD_FREE, 10'd2);
    send_cmd(CMD_FREE, 10'd2);
    send_cmd(CMD_ALLOC, 10'd0);
    send_cmd(CMD_EXTEND, 10'd0);
    send_cmd(CMD_FREE, 10'd0);
    send_cmd(CMD_FOLLOW, 10'd0);
    send_cmd(CMD_ALLOC, 10'd0);
    send_cmd(CMD_FREE, 10'd1);
    send_cmd(CMD_ALLOC, 10'd682);
    send_cmd(CMD_FREE, 10'd1023);
    send_cmd(CMD_FOLLOW, 10'd1);

    run_random(190, 20);

    tx_idle_pct = 79;
    rx_idle_pct = 28;
    run_random(190, 20);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    long_hold_req = 1'b1;
    run_random(20, 20);

    send_cmd(CMD_ALLOC, pick_block(PICK_ANY));
    send_cmd(CMD_EXTEND, pick_block(PICK_TAIL));
    send_cmd(CMD_FOLLOW, pick_block(PICK_USED));

    run_random(160, 55);

    while (sb.awaited_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.failed()) begin
      $display("RESULT: ERROR");
    end else begin
      $display("RESULT: OK");
    end
    $finish;
  end

endmodule
